### design/edit_distance_engine_core_macros.svh
// Assertion macros shared by the edit distance engine RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef EDIT_DISTANCE_ENGINE_CORE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define EDE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ede_pkg.sv
// Shared types and codes for the edit distance engine.
// No dependencies; used by ede_cell and edit_distance_engine_core.
package ede_pkg;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_PROCESS = 2'd1,
      ACT_REPORT  = 2'd2
   } action_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic       load;
      logic       clear;
      logic [7:0] symbol;
   } cell_ctl_type;

   // tag that rides along with the wavefront
   typedef struct packed {
      logic       valid;
      logic [7:0] sym;
   } wave_tag_type;

endpackage

### design/ede_cell.sv
// One column of the distance row: stores a second-word symbol and its distance.
// Depends on ede_pkg; instantiated in a chain by edit_distance_engine_core.
module ede_cell #(
   parameter int DW = 9,
   parameter int LW = 7,
   parameter int J  = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ede_pkg::cell_ctl_type ctl_i,
   input  logic [LW-1:0]        load_idx_i,
   input  ede_pkg::wave_tag_type tag_i,
   input  logic [DW-1:0]        left_i,
   input  logic [DW-1:0]        diag_i,
   output ede_pkg::wave_tag_type tag_o,
   output logic [DW-1:0]        left_o,
   output logic [DW-1:0]        diag_o
);
   import ede_pkg::*;

   localparam logic [DW-1:0] INIT = DW'(J);
   localparam logic [LW-1:0] SLOT = LW'(J - 1);

   logic [7:0]    sym_ff, sym_in;
   logic          active_ff, active_in;
   logic [DW-1:0] value_ff, value_in;
   wave_tag_type  tag_ff, tag_in;
   logic [DW-1:0] wleft_ff, wleft_in;
   logic [DW-1:0] wdiag_ff, wdiag_in;

   logic [DW-1:0] min_lu, min_all, cost;
   logic          hit;

   always_comb begin
      hit     = (sym_ff == tag_i.sym);
      min_lu  = (left_i < value_ff) ? left_i : value_ff;
      min_all = (min_lu < diag_i) ? min_lu : diag_i;
      cost    = hit ? diag_i : (min_all + DW'(1));
   end

   always_comb begin
      value_in  = value_ff;
      active_in = active_ff;
      sym_in    = sym_ff;
      if (ctl_i.clear) begin
         value_in  = INIT;
         active_in = 1'b0;
      end else begin
         if (tag_i.valid && active_ff) begin
            value_in = cost;
         end
         if (ctl_i.load && (load_idx_i == SLOT)) begin
            active_in = 1'b1;
            sym_in    = ctl_i.symbol;
         end
      end
      tag_in   = tag_i;
      // columns past the second word just forward the left value
      wleft_in = active_ff ? cost : left_i;
      wdiag_in = value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         value_ff     <= INIT;
         tag_ff.valid <= 1'b0;
      end else begin
         active_ff    <= active_in;
         value_ff     <= value_in;
         tag_ff.valid <= tag_in.valid;
      end
      tag_ff.sym <= tag_in.sym;
      sym_ff     <= sym_in;
      wleft_ff   <= wleft_in;
      wdiag_ff   <= wdiag_in;
   end

   assign tag_o  = tag_ff;
   assign left_o = wleft_ff;
   assign diag_o = wdiag_ff;

endmodule

### design/edit_distance_engine_core.sv
// Levenshtein edit distance engine, top level.
// Depends on ede_pkg, ede_cell and edit_distance_engine_core_macros.svh.
//
// Usage: words enter on req_; each carries an action and a symbol. Load words
// append a symbol of the second word, process words stream one symbol of the
// first word, a report word returns the distance and overflow flag on rsp_
// and clears the block for the next pair. Load and process give no rsp word.
// The distance row lives in a chain of SECOND_MAX cells; each process word
// launches a wavefront that moves one cell per clock, so process words are
// taken every cycle back to back. A report waits until the last wavefront has
// left the chain, as tracked by a drain counter, and its rsp word is valid the
// cycle after it is taken.
// Loads are taken every cycle. Loads after processing began are ignored;
// symbols beyond capacity are dropped and set the sticky overflow flag.
// The rsp word sits in an output register; while rsp_tready is low, loads
// and process words are still taken, and only a further report waits.
// Reset clears the row to 0..SECOND_MAX, both lengths and the flag; no
// clearing pass is needed and the block is ready the cycle after reset.
`include "edit_distance_engine_core_macros.svh"

module edit_distance_engine_core #(
   parameter int SECOND_MAX = 64,
   parameter int FIRST_MAX  = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] action, [9:2] symbol, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] distance, [8] overflow, rest zero
);
   import ede_pkg::*;

   localparam int MAXLEN = (FIRST_MAX > SECOND_MAX) ? FIRST_MAX : SECOND_MAX;
   localparam int DW     = $clog2(MAXLEN + 1);
   localparam int LW     = $clog2(SECOND_MAX + 1);
   localparam int FW     = $clog2(FIRST_MAX + 1);
   localparam int CW     = $clog2(SECOND_MAX + 2);
   localparam int XW     = DW + 8;

   localparam logic [LW-1:0] SECOND_FULL = LW'(SECOND_MAX);
   localparam logic [FW-1:0] FIRST_FULL  = FW'(FIRST_MAX);
   localparam logic [CW-1:0] DRAIN_LEN   = CW'(SECOND_MAX + 1);

   wave_tag_type  chain_tag  [0:SECOND_MAX];
   logic [DW-1:0] chain_left [0:SECOND_MAX];
   logic [DW-1:0] chain_diag [0:SECOND_MAX];

   logic [LW-1:0] second_len_ff, second_len_in;
   logic [FW-1:0] first_len_ff, first_len_in;
   logic          ovf_ff, ovf_in;
   logic [DW-1:0] result_ff, result_in;
   logic [CW-1:0] drain_ff, drain_in;
   wave_tag_type  inj_tag_ff, inj_tag_in;
   logic [DW-1:0] inj_left_ff, inj_left_in;
   logic [DW-1:0] inj_diag_ff, inj_diag_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_dist_ff, rsp_dist_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   cell_ctl_type  ctl;
   action_type    action;
   logic [7:0]    symbol;
   logic          req_accept;
   logic          rsp_free;
   logic [XW-1:0] result_ext;
   logic [7:0]    result_sat;

   assign action     = action_type'(req_tdata[1:0]);
   assign symbol     = req_tdata[9:2];
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign result_ext = XW'(result_ff);
   assign result_sat = (result_ext > XW'(255)) ? 8'hFF : result_ext[7:0];

   always_comb begin
      unique case (action)
         ACT_REPORT: req_tready = (drain_ff == '0) && rsp_free;
         default:    req_tready = 1'b1;
      endcase
   end

   // wavefront entry point: column 0 of the row is first_len itself
   assign chain_tag[0]  = inj_tag_ff;
   assign chain_left[0] = inj_left_ff;
   assign chain_diag[0] = inj_diag_ff;

   for (genvar g = 1; g <= SECOND_MAX; g++) begin : g_cell
      ede_cell #(
         .DW (DW),
         .LW (LW),
         .J  (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl_i      (ctl),
         .load_idx_i (second_len_ff),
         .tag_i      (chain_tag[g-1]),
         .left_i     (chain_left[g-1]),
         .diag_i     (chain_diag[g-1]),
         .tag_o      (chain_tag[g]),
         .left_o     (chain_left[g]),
         .diag_o     (chain_diag[g])
      );
   end

   always_comb begin
      second_len_in    = second_len_ff;
      first_len_in     = first_len_ff;
      ovf_in           = ovf_ff;
      result_in        = result_ff;
      drain_in         = (drain_ff != '0) ? (drain_ff - CW'(1)) : drain_ff;
      inj_tag_in.valid = 1'b0;
      inj_tag_in.sym   = symbol;
      inj_left_in      = DW'(first_len_ff) + DW'(1);
      inj_diag_in      = DW'(first_len_ff);
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_dist_in      = rsp_dist_ff;
      rsp_ovf_in       = rsp_ovf_ff;
      ctl.load         = 1'b0;
      ctl.clear        = 1'b0;
      ctl.symbol       = symbol;

      // last column's value leaves the chain as the row end
      if (chain_tag[SECOND_MAX].valid) begin
         result_in = chain_left[SECOND_MAX];
      end

      if (req_accept) begin
         unique case (action)
            ACT_LOAD: begin
               if (first_len_ff == '0) begin
                  if (second_len_ff == SECOND_FULL) begin
                     ovf_in = 1'b1;
                  end else begin
                     ctl.load      = 1'b1;
                     second_len_in = second_len_ff + LW'(1);
                     result_in     = DW'(second_len_ff) + DW'(1);
                  end
               end
            end
            ACT_PROCESS: begin
               if (first_len_ff == FIRST_FULL) begin
                  ovf_in = 1'b1;
               end else begin
                  first_len_in     = first_len_ff + FW'(1);
                  inj_tag_in.valid = 1'b1;
                  drain_in         = DRAIN_LEN;
               end
            end
            ACT_REPORT: begin
               rsp_valid_in  = 1'b1;
               rsp_dist_in   = result_sat;
               rsp_ovf_in    = ovf_ff;
               ctl.clear     = 1'b1;
               second_len_in = '0;
               first_len_in  = '0;
               ovf_in        = 1'b0;
               result_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_len_ff    <= '0;
         first_len_ff     <= '0;
         ovf_ff           <= 1'b0;
         result_ff        <= '0;
         drain_ff         <= '0;
         inj_tag_ff.valid <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         second_len_ff    <= second_len_in;
         first_len_ff     <= first_len_in;
         ovf_ff           <= ovf_in;
         result_ff        <= result_in;
         drain_ff         <= drain_in;
         inj_tag_ff.valid <= inj_tag_in.valid;
         rsp_valid_ff     <= rsp_valid_in;
      end
      inj_tag_ff.sym <= inj_tag_in.sym;
      inj_left_ff    <= inj_left_in;
      inj_diag_ff    <= inj_diag_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ovf_ff, rsp_dist_ff};

   `EDE_ASSERT_NEXT(a_report_clears, clock, reset, req_accept && (action == ACT_REPORT), rsp_tvalid && (second_len_ff == '0) && (first_len_ff == '0) && !ovf_ff, "report did not clear block")
   `EDE_ASSERT_NOW(a_inject_tracked, clock, reset, inj_tag_ff.valid, drain_ff != '0, "wavefront launched without drain count")
   `EDE_ASSERT_NOW(a_exit_tracked, clock, reset, chain_tag[SECOND_MAX].valid, drain_ff != '0, "wavefront outlived drain count")
   `EDE_ASSERT_NOW(a_len_bound, clock, reset, 1'b1, (second_len_ff <= SECOND_FULL) && (first_len_ff <= FIRST_FULL), "length beyond capacity")

endmodule

### tb/sv/edit_distance_engine_core_tb.sv
// Self-checking bench for edit_distance_engine_core: streams load, process and
// report words, predicts each report's distance and overflow flag.
// Depends on ede_pkg and the edit_distance_engine_core RTL.
`timescale 1ns / 100ps

module edit_distance_engine_core_tb;
   import ede_pkg::*;

   localparam int SEC_CAP   = 64;
   localparam int FIRST_CAP = 255;
   localparam int WATCHDOG  = 4000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [7:0] distance;
      logic       overflow;
   } report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [1:0] action, [9:2] symbol
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [7:0] distance, [8] overflow

   logic [15:0] word_queue[$];
   report_type  pending_reports[$];
   int          word_total = 0;
   int          mismatch_count = 0;
   int          idle_cycles = 0;

   // predictor state
   logic [7:0]  second_word[SEC_CAP];
   int          dist_row[SEC_CAP + 1];
   int          second_len;
   int          first_len;
   logic        overflow_seen;

   edit_distance_engine_core #(
      .SECOND_MAX(SEC_CAP),
      .FIRST_MAX (FIRST_CAP)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_pair();
      for (int j = 0; j <= SEC_CAP; j++) dist_row[j] = j;
      second_len    = 0;
      first_len     = 0;
      overflow_seen = 1'b0;
   endfunction

   function automatic void predict_word(logic [1:0] act, logic [7:0] sym);
      int diag;
      int up;
      int nxt;
      report_type rep;
      case (act)
         ACT_LOAD: begin
            // loads are ignored once the first word has started
            if (first_len == 0) begin
               if (second_len >= SEC_CAP) begin
                  overflow_seen = 1'b1;
               end else begin
                  second_word[second_len] = sym;
                  second_len++;
               end
            end
         end
         ACT_PROCESS: begin
            if (first_len >= FIRST_CAP) begin
               overflow_seen = 1'b1;
            end else begin
               first_len++;
               diag = dist_row[0];
               dist_row[0] = first_len;
               for (int j = 1; j <= second_len; j++) begin
                  up = dist_row[j];
                  if (second_word[j - 1] == sym) begin
                     nxt = diag;
                  end else begin
                     nxt = dist_row[j - 1];
                     if (up < nxt) nxt = up;
                     if (diag < nxt) nxt = diag;
                     nxt = nxt + 1;
                  end
                  diag = up;
                  dist_row[j] = nxt;
               end
            end
         end
         ACT_REPORT: begin
            rep.distance = (dist_row[second_len] > 255) ? 8'd255 : dist_row[second_len][7:0];
            rep.overflow = overflow_seen;
            pending_reports.push_back(rep);
            clear_pair();
         end
         default: ;
      endcase
   endfunction

   // mostly short gaps, a few long ones; none in calm stretches
   function automatic int draw_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_symbol(bit narrow, logic [7:0] base, int span);
      if (narrow) return base + 8'($urandom_range(0, span - 1));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_word(logic [1:0] act, logic [7:0] sym);
      word_queue.push_back({6'b0, sym, act});
      word_total++;
   endtask

   // one well-formed pair; noisy pairs get stray loads and unused actions
   task automatic build_pair(int len2, int len1, bit narrow, bit noisy);
      logic [7:0] base;
      int span;
      base = 8'($urandom_range(0, 255));
      span = $urandom_range(1, 4);
      for (int i = 0; i < len2; i++) begin
         queue_word(ACT_LOAD, pick_symbol(narrow, base, span));
         if (noisy && $urandom_range(0, 9) == 0)
            queue_word(ACT_UNUSED, 8'($urandom_range(0, 255)));
      end
      for (int i = 0; i < len1; i++) begin
         queue_word(ACT_PROCESS, pick_symbol(narrow, base, span));
         if (noisy && $urandom_range(0, 6) == 0)
            queue_word($urandom_range(0, 1) ? ACT_LOAD : ACT_UNUSED,
                       8'($urandom_range(0, 255)));
      end
      queue_word(ACT_REPORT, 8'($urandom_range(0, 255)));
   endtask

   // driver
   int  req_gap = 0;
   bit  req_calm = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         clear_pair();
      end else begin
         if (req_tvalid && req_tready) predict_word(req_tdata[1:0], req_tdata[9:2]);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (word_queue.size() > 0) begin
               req_tdata  <= word_queue.pop_front();
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 79) == 0) req_calm = !req_calm;
               req_gap = draw_gap(req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int  rsp_stall = 0;
   bit  rsp_calm = 1'b0;
   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_reports.size() == 0) begin
               $error("rsp word with no report pending: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = pending_reports.pop_front();
               if (rsp_tdata[7:0] !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance, rsp_tdata[7:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[8] !== want.overflow) begin
                  $error("overflow: expected %0d, got %0d", want.overflow, rsp_tdata[8]);
                  mismatch_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 59) == 0) rsp_calm = !rsp_calm;
            if ($urandom_range(0, 3) == 0) rsp_stall = draw_gap(rsp_calm);
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("edit_distance_engine_core test failed");
            $finish;
         end
      end
   end

   initial begin
      int r;
      int n;
      int len1;
      int len2;

      // directed: empty pair, extreme symbols, equal words, stray words
      queue_word(ACT_REPORT, 8'h00);
      queue_word(ACT_LOAD, 8'h00);
      queue_word(ACT_LOAD, 8'hFF);
      queue_word(ACT_REPORT, 8'hFF);
      queue_word(ACT_PROCESS, 8'hFF);
      queue_word(ACT_PROCESS, 8'h00);
      queue_word(ACT_REPORT, 8'h00);
      queue_word(ACT_LOAD, 8'h61);
      queue_word(ACT_LOAD, 8'h62);
      queue_word(ACT_UNUSED, 8'hFF);
      queue_word(ACT_LOAD, 8'h63);
      queue_word(ACT_PROCESS, 8'h61);
      queue_word(ACT_LOAD, 8'h7A);      // ignored, processing began
      queue_word(ACT_PROCESS, 8'h62);
      queue_word(ACT_PROCESS, 8'h63);
      queue_word(ACT_REPORT, 8'hAA);
      queue_word(ACT_LOAD, 8'hAA);
      queue_word(ACT_LOAD, 8'h55);
      queue_word(ACT_PROCESS, 8'h55);
      queue_word(ACT_PROCESS, 8'hAA);
      queue_word(ACT_PROCESS, 8'h00);
      queue_word(ACT_REPORT, 8'h55);

      // second word past capacity, then first word past capacity
      build_pair(SEC_CAP + 2, 3, 1'b1, 1'b0);
      build_pair(2, FIRST_CAP + 3, 1'b0, 1'b0);

      while (word_total < 650) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
               queue_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            queue_word(ACT_REPORT, 8'($urandom_range(0, 255)));
         end else begin
            r = $urandom_range(0, 99);
            len2 = (r < 80) ? $urandom_range(0, 8) :
                   (r < 95) ? $urandom_range(9, 30) : $urandom_range(SEC_CAP - 4, SEC_CAP + 2);
            r = $urandom_range(0, 99);
            len1 = (r < 80) ? $urandom_range(0, 10) :
                   (r < 98) ? $urandom_range(11, 40) : $urandom_range(FIRST_CAP - 5, FIRST_CAP + 1);
            build_pair(len2, len1, $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (word_queue.size() > 0 || req_tvalid) @(posedge clock);
      while (pending_reports.size() > 0) @(posedge clock);
      repeat (SEC_CAP + 10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("edit_distance_engine_core test passed");
      end else begin
         $display("edit_distance_engine_core test failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/ede_pkg.sv
design/ede_cell.sv
design/edit_distance_engine_core.sv
tb/sv/edit_distance_engine_core_tb.sv
